// ===== rtl/ham_palette_pixel_decoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// ham_palette_pixel_decoder_unit_defines
// Assertion macros shared by the checker of the palette pixel decoder.
// ----------------------------------------------------------------------------
`ifndef HAM_PALETTE_PIXEL_DECODER_UNIT_DEFINES_SVH
`define HAM_PALETTE_PIXEL_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define HPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpd assertion failed");

// next-cycle implication
`define HPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpd assertion failed");

`endif

// ===== rtl/hpd_pkg.sv =====
// ----------------------------------------------------------------------------
// hpd_pkg
// Types and constants of the palette pixel decoder.
// ----------------------------------------------------------------------------
package hpd_pkg;

  localparam int CODE_W        = 8;
  localparam int CNT_W         = 9;
  localparam int CB_W          = 4;
  localparam int TIDX_W        = 16;
  localparam int PAL_W         = 24;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int PAL_DEPTH_DEF = 256;
  localparam int CB_MAX        = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TRUE_COLOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_BITS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HAM_ENABLE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSP_ENABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSP_INDEX  = 3'd5;

  localparam logic [CB_W-1:0] COLOR_BITS_RST = 4'd4;

  localparam logic [1:0] CTRL_BLUE = 2'd1;
  localparam logic [1:0] CTRL_RED  = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic                  true_color;
    logic [CNT_W-1:0]      palette_count;
    logic [CB_W-1:0]       color_bits;
    logic                  ham_enable;
    logic                  transp_enable;
    logic [TIDX_W-1:0]     transp_index;
  } cfg_t;

  // red in the lowest byte
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } rgba_t;

  localparam rgba_t OPAQUE_BLACK = '{a: 8'hFF, b: 8'h00, g: 8'h00, r: 8'h00};

endpackage

// ===== rtl/hpd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// hpd_cfg_regs
// Configuration register file, written through the cfg channel.
// ----------------------------------------------------------------------------
module hpd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [hpd_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [hpd_pkg::CFG_DATA_W-1:0]  wr_data,
  output hpd_pkg::cfg_t                   cfg
);
  import hpd_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.true_color    <= 1'b0;
      cfg_r.palette_count <= '0;
      cfg_r.color_bits    <= COLOR_BITS_RST;
      cfg_r.ham_enable    <= 1'b0;
      cfg_r.transp_enable <= 1'b0;
      cfg_r.transp_index  <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_TRUE_COLOR:    cfg_r.true_color    <= wr_data[0];
        REG_PALETTE_COUNT: cfg_r.palette_count <= wr_data[CNT_W-1:0];
        REG_COLOR_BITS:    cfg_r.color_bits    <= wr_data[CB_W-1:0];
        REG_HAM_ENABLE:    cfg_r.ham_enable    <= wr_data[0];
        REG_TRANSP_ENABLE: cfg_r.transp_enable <= wr_data[0];
        REG_TRANSP_INDEX:  cfg_r.transp_index  <= wr_data[TIDX_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/hpd_palette_ram.sv =====
// ----------------------------------------------------------------------------
// hpd_palette_ram
// Palette store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hpd_palette_ram #(
  parameter int DEPTH = hpd_pkg::PAL_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [hpd_pkg::PAL_W-1:0]  wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [hpd_pkg::PAL_W-1:0]  rdata
);
  import hpd_pkg::*;

  logic [PAL_W-1:0] mem [DEPTH];
  logic [PAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/hpd_mod_unit.sv =====
// ----------------------------------------------------------------------------
// hpd_mod_unit
// Restoring remainder unit: code modulo count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hpd_mod_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [hpd_pkg::CODE_W-1:0]   dividend,
  input  logic [hpd_pkg::CNT_W-1:0]    divisor,
  output logic                         done,
  output logic [hpd_pkg::CODE_W-1:0]   remainder
);
  import hpd_pkg::*;

  localparam int SW = $clog2(CODE_W);

  logic              busy_r;
  logic              done_r;
  logic [SW-1:0]     step_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CODE_W-1:0] dvd_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [CNT_W-1:0]  trial;
  logic [CNT_W-1:0]  rem_nxt;

  // remainder before a shift is below the divisor, so it fits in CODE_W bits
  assign trial   = {rem_r[CODE_W-1:0], dvd_r[step_r]};
  assign rem_nxt = (trial >= dvs_r) ? (trial - dvs_r) : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= SW'(CODE_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - SW'(1);
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r[CODE_W-1:0];

endmodule

// ===== rtl/ham_palette_pixel_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// ham_palette_pixel_decoder_unit
// Palette / hold-and-modify pixel decoder producing RGBA pixels.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes registers (index, data); always ready, write only idle.
//   in channel carries palette write items (tuser[0]=1) and pixel items.
//   A palette write gives no result; in_tready stays high.
//   A pixel item reads the palette RAM (registered read), then decodes.
//   Palette, true-color, error and zero-count hold-and-modify pixels pass
//   through S_CALC to S_OUT, where the result loads the output register and
//   the input reopens.
//   Hold-and-modify with nonzero count runs the 8-step remainder unit in S_DIV
//   before S_OUT; the input stays closed until the result loads.
//   The output register holds a result while out_tready is low; the block
//   accepts the next item then, but a new result waits until the register
//   drains.
//   Reset (rst_n low, synchronous) clears the registers to their defaults,
//   the held color to opaque black, and empties the output register.
//   Palette RAM contents are undefined until written.
// ----------------------------------------------------------------------------
module ham_palette_pixel_decoder_unit #(
  parameter int PALETTE_DEPTH = hpd_pkg::PAL_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // cfg channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hpd_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // pixel_code, palette_address, red_in, green_in, blue_in
  input  logic [39:0]                     in_tdata,
  // func, first_of_row
  input  logic [1:0]                      in_tuser,
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // red_out, green_out, blue_out, alpha_out
  output logic [31:0]                     out_tdata,
  // status
  output logic                            out_tuser
);
  import hpd_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  function automatic rgba_t ham_mod(rgba_t c, logic [CODE_W-1:0] code,
                                    logic [CODE_W-1:0] base, logic [CB_W-1:0] cb);
    logic [1:0]  ctl;
    logic [CB_W-1:0] sh;
    logic [15:0] wide;
    rgba_t       o;
    o   = c;
    ctl = 2'd0;
    sh  = '0;
    if (cb < CB_W'(CB_MAX)) begin
      ctl = 2'(code >> cb);
      sh  = CB_W'(CB_MAX) - cb;
    end
    wide = {8'd0, base} << sh;
    case (ctl)
      CTRL_BLUE: o.b = wide[7:0];
      CTRL_RED:  o.r = wide[7:0];
      default:   o.g = wide[7:0];
    endcase
    return o;
  endfunction

  cfg_t cfg;

  logic [1:0]        state_r, state_nxt;
  logic [CODE_W-1:0] code_r;
  logic              first_r;
  logic [7:0]        red_r, green_r, blue_r;
  rgba_t             color_r, color_nxt;
  logic              stat_r, stat_nxt;
  rgba_t             held_r;
  rgba_t             out_data_r;
  logic              out_user_r;
  logic              out_valid_r;

  logic              accept, is_wr;
  logic [CODE_W-1:0] in_code, in_addr;
  logic [PAL_W-1:0]  pal_rdata;
  logic [CNT_W-1:0]  cnt_eff;
  logic              in_pal;
  logic              div_start, div_done;
  logic [CODE_W-1:0] div_rem;
  logic              out_load;
  rgba_t             start_color, pal_color;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign is_wr     = in_tuser[0];
  assign in_code   = in_tdata[7:0];
  assign in_addr   = in_tdata[15:8];

  hpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  hpd_palette_ram #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (accept & is_wr & (CNT_W'(in_addr) < CNT_W'(PALETTE_DEPTH))),
    .waddr (in_addr[AW-1:0]),
    .wdata ({in_tdata[23:16], in_tdata[31:24], in_tdata[39:32]}),
    .re    (accept & ~is_wr),
    .raddr (in_code[AW-1:0]),
    .rdata (pal_rdata)
  );

  assign cnt_eff = (cfg.palette_count < CNT_W'(PALETTE_DEPTH)) ?
                   cfg.palette_count : CNT_W'(PALETTE_DEPTH);
  assign in_pal  = CNT_W'(code_r) < cnt_eff;

  assign div_start = (state_r == S_CALC) & ~cfg.true_color & ~in_pal &
                     cfg.ham_enable & (cnt_eff != '0);

  hpd_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (code_r),
    .divisor   (cnt_eff),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign start_color = first_r ? OPAQUE_BLACK : held_r;

  always_comb begin
    pal_color   = '{a: 8'hFF, r: pal_rdata[23:16], g: pal_rdata[15:8], b: pal_rdata[7:0]};
    if (cfg.transp_enable && (TIDX_W'(code_r) == cfg.transp_index)) begin
      pal_color.a = 8'h00;
    end
  end

  assign out_load = (state_r == S_OUT) & (~out_valid_r | out_tready);

  always_comb begin
    state_nxt = state_r;
    color_nxt = color_r;
    stat_nxt  = stat_r;
    case (state_r)
      S_IDLE: begin
        if (accept && !is_wr) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        stat_nxt  = STATUS_OK;
        state_nxt = S_OUT;
        if (cfg.true_color) begin
          color_nxt = '{a: 8'hFF, r: red_r, g: green_r, b: blue_r};
        end else if (in_pal) begin
          color_nxt = pal_color;
        end else if (cfg.ham_enable) begin
          if (cnt_eff == '0) begin
            color_nxt = ham_mod(start_color, code_r, code_r, cfg.color_bits);
          end else begin
            color_nxt = start_color;
            state_nxt = S_DIV;
          end
        end else begin
          color_nxt = start_color;
          stat_nxt  = STATUS_ERR;
        end
      end
      S_DIV: begin
        if (div_done) begin
          color_nxt = ham_mod(color_r, code_r, div_rem, cfg.color_bits);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      held_r      <= OPAQUE_BLACK;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
        held_r      <= color_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    color_r <= color_nxt;
    stat_r  <= stat_nxt;
    if (accept && !is_wr) begin
      code_r  <= in_code;
      first_r <= in_tuser[1];
      red_r   <= in_tdata[23:16];
      green_r <= in_tdata[31:24];
      blue_r  <= in_tdata[39:32];
    end
    if (out_load) begin
      out_data_r <= color_r;
      out_user_r <= stat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== rtl/hpd_checker.sv =====
// ----------------------------------------------------------------------------
// hpd_checker
// Port-level assertions for the palette pixel decoder, bound to the top.
// ----------------------------------------------------------------------------
`include "ham_palette_pixel_decoder_unit_defines.svh"

module hpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // stalled result holds
  `HPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // pixel item blocks the input in the following cycle
  `HPD_ASSERT_NEXT(a_pix_busy, clk, rst_n, in_tvalid && in_tready && !in_tuser[0], !in_tready)

  // palette write leaves the input ready
  `HPD_ASSERT_NEXT(a_wr_ready, clk, rst_n, in_tvalid && in_tready && in_tuser[0], in_tready)

  // a new result comes with the input open again
  `HPD_ASSERT_NOW(a_out_idle, clk, rst_n, $rose(out_tvalid), in_tready)

endmodule

bind ham_palette_pixel_decoder_unit hpd_checker u_hpd_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hold-and-modify palette pixel decoder.
// A directed table covers reset behavior, palette lookup, transparency,
// every hold-and-modify channel, zero count, wide and zero color_bits, true
// color, count beyond depth and the out-of-palette error. Randomized phases follow,
// each under its own register setting. Each pixel is checked against its table
// value or a decoder model; both sides idle randomly, bar the last four phases.
// ----------------------------------------------------------------------------
module tb;
  import hpd_pkg::*;

  localparam int PAL_DEPTH       = PAL_DEPTH_DEF;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 104;
  localparam int DRAIN_CYCLES    = 16;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int TIMEOUT_NS      = 5_000_000;

  typedef struct packed {
    logic       func;
    logic       first;
    logic [7:0] code;
    logic [7:0] addr;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_item_t;

  typedef struct packed {
    rgba_t px;
    logic  st;
  } pixel_result_t;

  typedef struct {
    bit            is_cfg;
    cfg_t          cfg;
    pix_item_t     it;
    bit            typed;
    pixel_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;  // pixel_code, palette_address, red_in, green_in, blue_in
  logic [1:0] in_tuser = '0;   // func, first_of_row
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;      // red_out, green_out, blue_out, alpha_out
  logic out_tuser;             // status

  ham_palette_pixel_decoder_unit #(.PALETTE_DEPTH(PAL_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #6 clk = ~clk;

  // decoder model state
  cfg_t          dec_cfg;
  rgba_t         held_px;
  logic [23:0]   pal_mem [PAL_DEPTH];
  bit            pal_loaded [PAL_DEPTH];
  pixel_result_t pixel_expect_q [$];
  stim_row_t     dir_rows [$];

  int send_idle = 7;
  int recv_idle = 68;
  int mismatch_count = 0;

  pixel_result_t want;
  rgba_t         got;

  function automatic cfg_t mk_cfg(bit tc, int unsigned cnt, int unsigned cb, bit ham, bit te,
                                  int unsigned ti);
    cfg_t c;
    c.true_color    = tc;
    c.palette_count = CNT_W'(cnt);
    c.color_bits    = CB_W'(cb);
    c.ham_enable    = ham;
    c.transp_enable = te;
    c.transp_index  = TIDX_W'(ti);
    return c;
  endfunction

  function automatic int unsigned eff_count();
    return (dec_cfg.palette_count < PAL_DEPTH) ? dec_cfg.palette_count : PAL_DEPTH;
  endfunction

  // returns 1 when the item yields a pixel
  function automatic bit decode_expect(input pix_item_t it, output pixel_result_t res);
    int unsigned cnt;
    int unsigned base;
    int unsigned shift;
    logic [1:0]  ctrl;
    logic [7:0]  comp;
    res.px = held_px;
    res.st = STATUS_OK;
    if (it.func) begin
      if (it.addr < PAL_DEPTH) begin
        pal_mem[it.addr] = {it.r, it.g, it.b};
        pal_loaded[it.addr] = 1'b1;
      end
      return 1'b0;
    end
    if (it.first) held_px = OPAQUE_BLACK;
    cnt = eff_count();
    if (dec_cfg.true_color) begin
      held_px = '{a: 8'hFF, b: it.b, g: it.g, r: it.r};
    end else if (it.code < cnt) begin
      held_px = '{a: 8'hFF, b: pal_mem[it.code][7:0], g: pal_mem[it.code][15:8],
                  r: pal_mem[it.code][23:16]};
      if (dec_cfg.transp_enable && TIDX_W'(it.code) == dec_cfg.transp_index) held_px.a = 8'h00;
    end else if (dec_cfg.ham_enable) begin
      ctrl = 2'd0;
      shift = 0;
      base = (cnt != 0) ? it.code % cnt : it.code;
      if (dec_cfg.color_bits < CB_MAX) begin
        ctrl = 2'(it.code >> dec_cfg.color_bits);
        shift = CB_MAX - dec_cfg.color_bits;
      end
      comp = 8'(base << shift);
      case (ctrl)
        CTRL_BLUE: held_px.b = comp;
        CTRL_RED:  held_px.r = comp;
        default:   held_px.g = comp;
      endcase
    end else begin
      res.st = STATUS_ERR;
    end
    res.px = held_px;
    return 1'b1;
  endfunction

  function automatic stim_row_t px_row(bit first, logic [7:0] code, logic [7:0] r,
                                       logic [7:0] g, logic [7:0] b);
    stim_row_t s;
    s.is_cfg = 1'b0;
    s.typed = 1'b0;
    s.it = '{func: 1'b0, first: first, code: code, addr: ~code, r: r, g: g, b: b};
    return s;
  endfunction

  function automatic stim_row_t wr_row(bit first, logic [7:0] addr, logic [7:0] r,
                                       logic [7:0] g, logic [7:0] b);
    stim_row_t s;
    s.is_cfg = 1'b0;
    s.typed = 1'b0;
    s.it = '{func: 1'b1, first: first, code: addr, addr: addr, r: r, g: g, b: b};
    return s;
  endfunction

  function automatic stim_row_t cfg_row(cfg_t c);
    stim_row_t s;
    s.is_cfg = 1'b1;
    s.typed = 1'b0;
    s.cfg = c;
    return s;
  endfunction

  function automatic stim_row_t checked(stim_row_t s, logic [7:0] r, logic [7:0] g,
                                        logic [7:0] b, logic [7:0] a, logic st);
    s.typed = 1'b1;
    s.want.px = '{a: a, b: b, g: g, r: r};
    s.want.st = st;
    return s;
  endfunction

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_config(cfg_t c);
    put_reg(REG_TRUE_COLOR, CFG_DATA_W'(c.true_color));
    put_reg(REG_PALETTE_COUNT, CFG_DATA_W'(c.palette_count));
    put_reg(REG_COLOR_BITS, CFG_DATA_W'(c.color_bits));
    put_reg(REG_HAM_ENABLE, CFG_DATA_W'(c.ham_enable));
    put_reg(REG_TRANSP_ENABLE, CFG_DATA_W'(c.transp_enable));
    put_reg(REG_TRANSP_INDEX, CFG_DATA_W'(c.transp_index));
    cfg_valid <= 1'b0;
    dec_cfg = c;
  endtask

  // in_tvalid stays high after an accept; drain() lowers it
  task automatic send_item(pix_item_t it, bit typed, pixel_result_t fixed);
    pixel_result_t res;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {it.b, it.g, it.r, it.addr, it.code};
    in_tuser <= {it.first, it.func};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (decode_expect(it, res)) pixel_expect_q.push_back(typed ? fixed : res);
  endtask

  // loads a never-written entry before any pixel looks it up
  task automatic feed(pix_item_t it, bit typed, pixel_result_t fixed);
    pix_item_t fill;
    if (!it.func && !dec_cfg.true_color && it.code < eff_count() && !pal_loaded[it.code]) begin
      fill = '{func: 1'b1, first: 1'b0, code: it.code, addr: it.code,
               r: 8'($urandom), g: 8'($urandom), b: 8'($urandom)};
      send_item(fill, 1'b0, fixed);
    end
    send_item(it, typed, fixed);
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (pixel_expect_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pixel_expect_q.size() != 0) begin
      $error("%0d pixels never came out", pixel_expect_q.size());
      mismatch_count++;
      pixel_expect_q.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_burst(int n);
    pix_item_t     it;
    pixel_result_t no_fixed;
    int unsigned   cnt;
    int unsigned   sel;
    no_fixed = '0;
    for (int i = 0; i < n; i++) begin
      it.func = 1'b0;
      it.first = ($urandom_range(9) == 0);
      it.code = 8'($urandom);
      it.addr = 8'($urandom);
      it.r = 8'($urandom);
      it.g = 8'($urandom);
      it.b = 8'($urandom);
      cnt = eff_count();
      sel = $urandom_range(99);
      if (sel < 8) begin
        it.func = 1'($urandom_range(1));
      end else if (sel < 25) begin
        it.func = 1'b1;
        if (cnt != 0 && $urandom_range(3) != 0) it.addr = 8'($urandom_range(cnt - 1));
      end else if (dec_cfg.ham_enable && cnt < PAL_DEPTH && $urandom_range(2) != 0) begin
        it.code = 8'($urandom_range(255, cnt));
      end else if (cnt != 0 && $urandom_range(3) != 0) begin
        it.code = 8'($urandom_range(cnt - 1));
      end
      feed(it, 1'b0, no_fixed);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pixel_expect_q.size() == 0) begin
        $error("unexpected pixel %h status %b", out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        want = pixel_expect_q.pop_front();
        got = out_tdata;
        if (got.r !== want.px.r) begin
          $error("red_out: expected %h, got %h", want.px.r, got.r);
          mismatch_count++;
        end
        if (got.g !== want.px.g) begin
          $error("green_out: expected %h, got %h", want.px.g, got.g);
          mismatch_count++;
        end
        if (got.b !== want.px.b) begin
          $error("blue_out: expected %h, got %h", want.px.b, got.b);
          mismatch_count++;
        end
        if (got.a !== want.px.a) begin
          $error("alpha_out: expected %h, got %h", want.px.a, got.a);
          mismatch_count++;
        end
        if (out_tuser !== want.st) begin
          $error("status: expected %b, got %b", want.st, out_tuser);
          mismatch_count++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : main_seq
    cfg_t c;
    dec_cfg = mk_cfg(1'b0, 0, COLOR_BITS_RST, 1'b0, 1'b0, 0);
    held_px = OPAQUE_BLACK;

    // after reset: count 0, no hold-and-modify, every pixel is an error
    dir_rows.push_back(checked(px_row(1, 8'h00, 8'h00, 8'h00, 8'h00),
                               8'h00, 8'h00, 8'h00, 8'hFF, STATUS_ERR));
    dir_rows.push_back(checked(px_row(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                               8'h00, 8'h00, 8'h00, 8'hFF, STATUS_ERR));
    dir_rows.push_back(cfg_row(mk_cfg(1'b0, 4, 4, 1'b1, 1'b1, 2)));
    dir_rows.push_back(wr_row(0, 8'h00, 8'hFF, 8'hFF, 8'hFF));
    dir_rows.push_back(wr_row(1, 8'hFF, 8'h12, 8'h34, 8'h56));
    dir_rows.push_back(wr_row(0, 8'h01, 8'h80, 8'h40, 8'h20));
    dir_rows.push_back(wr_row(0, 8'h02, 8'hAA, 8'hBB, 8'hCC));
    dir_rows.push_back(wr_row(0, 8'h03, 8'h01, 8'h02, 8'h04));
    dir_rows.push_back(checked(px_row(1, 8'h00, 8'h00, 8'h00, 8'h00),
                               8'hFF, 8'hFF, 8'hFF, 8'hFF, STATUS_OK));
    // transparent index, then modified channels keep alpha
    dir_rows.push_back(checked(px_row(0, 8'h02, 8'h00, 8'h00, 8'h00),
                               8'hAA, 8'hBB, 8'hCC, 8'h00, STATUS_OK));
    dir_rows.push_back(px_row(0, 8'h15, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(px_row(0, 8'h25, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(px_row(0, 8'h35, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(px_row(0, 8'h05, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(checked(px_row(1, 8'h03, 8'h00, 8'h00, 8'h00),
                               8'h01, 8'h02, 8'h04, 8'hFF, STATUS_OK));
    dir_rows.push_back(cfg_row(mk_cfg(1'b0, 0, 4, 1'b1, 1'b0, 0)));
    dir_rows.push_back(px_row(1, 8'hFF, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(cfg_row(mk_cfg(1'b0, 2, 8, 1'b1, 1'b0, 0)));
    dir_rows.push_back(px_row(0, 8'hA7, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(cfg_row(mk_cfg(1'b0, 1, 0, 1'b1, 1'b0, 0)));
    dir_rows.push_back(px_row(0, 8'h02, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(cfg_row(mk_cfg(1'b1, 256, 15, 1'b0, 1'b1, 16'hFFFF)));
    dir_rows.push_back(checked(px_row(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                               8'hFF, 8'hFF, 8'hFF, 8'hFF, STATUS_OK));
    dir_rows.push_back(checked(px_row(1, 8'h00, 8'h00, 8'h00, 8'h00),
                               8'h00, 8'h00, 8'h00, 8'hFF, STATUS_OK));
    // count above depth clips to depth
    dir_rows.push_back(cfg_row(mk_cfg(1'b0, 511, 4, 1'b0, 1'b1, 255)));
    dir_rows.push_back(checked(px_row(0, 8'hFF, 8'h00, 8'h00, 8'h00),
                               8'h12, 8'h34, 8'h56, 8'h00, STATUS_OK));
    dir_rows.push_back(checked(px_row(0, 8'h01, 8'h00, 8'h00, 8'h00),
                               8'h80, 8'h40, 8'h20, 8'hFF, STATUS_OK));
    dir_rows.push_back(cfg_row(mk_cfg(1'b0, 3, 4, 1'b0, 1'b0, 0)));
    dir_rows.push_back(checked(px_row(0, 8'h03, 8'h00, 8'h00, 8'h00),
                               8'h80, 8'h40, 8'h20, 8'hFF, STATUS_ERR));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        apply_config(dir_rows[i].cfg);
      end else begin
        feed(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p / 4)
        0: begin
          send_idle = 7;
          recv_idle = 68;
        end
        1: begin
          send_idle = 68;
          recv_idle = 7;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      case (p)
        0: c = mk_cfg(1'b0, 16, 4, 1'b1, 1'b1, $urandom_range(15));
        1: c = mk_cfg(1'b0, 64, 6, 1'b1, 1'b1, $urandom_range(63));
        2: c = mk_cfg(1'b0, 256, 8, 1'b1, 1'b1, 255);
        4: c = mk_cfg(1'b0, 0, 4, 1'b1, 1'b0, 0);
        5: c = mk_cfg(1'b0, 32, 5, 1'b0, 1'b1, $urandom_range(31));
        6: c = mk_cfg(1'b1, $urandom_range(511), $urandom_range(15), 1'b1, 1'b1, $urandom);
        default: begin
          c = mk_cfg($urandom_range(5) == 0,
                     ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(256),
                     ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(8),
                     1'($urandom_range(1)), 1'($urandom_range(1)),
                     ($urandom_range(1) == 0) ? $urandom_range(255) : $urandom);
        end
      endcase
      drain();
      apply_config(c);
      random_burst(ITEMS_PER_PHASE);
    end

    drain();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hpd_pkg.sv
rtl/hpd_cfg_regs.sv
rtl/hpd_palette_ram.sv
rtl/hpd_mod_unit.sv
rtl/ham_palette_pixel_decoder_unit.sv
rtl/hpd_checker.sv
test/tb.sv
